// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Concurrent assertion helpers shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/nnu_pkg.sv =====
// ----------------------------------------------------------------------------
// nnu_pkg
// Widths, constants, the control state type and the accumulator control
// group shared by the neighbor normal unevenness block.
// ----------------------------------------------------------------------------
`default_nettype none

package nnu_pkg;

  localparam int NORM_W     = 16;
  localparam int ACC_W      = 24;
  localparam int DIGIT_W    = 8;
  localparam int ACC_DIGITS = ACC_W / DIGIT_W;
  localparam int DIG_CNT_W  = 2;
  localparam int SQ_W       = 48;
  localparam int RAD_SHIFT  = 4;
  localparam int RAD_W      = SQ_W + RAD_SHIFT;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int REM_W      = ROOT_W + 1;
  localparam int STEP_CNT_W = 5;
  localparam int FLAT_SHIFT = 29;
  localparam int UNEV_W     = 17;

  localparam logic [UNEV_W-1:0] UNEV_MAX    = 17'h10000;
  localparam logic [ACC_W-1:0]  ACC_POS_MAX = 24'h7FFFFF;
  localparam logic [ACC_W-1:0]  ACC_NEG_MIN = 24'h800000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_SQ_GO,
    ST_SQ,
    ST_ROOT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic step;
    logic final_digit;
  } acc_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/neighbor_normal_unevenness_top.sv =====
// ----------------------------------------------------------------------------
// neighbor_normal_unevenness_top
// Sums the neighbor normals of one point and reports the vector sum together
// with its length over the neighbor count as an unevenness value.
//
// The input channel carries one neighbor normal per request (signed Q1.14)
// with a last flag and an empty-neighborhood flag. Each neighbor is taken
// in an accept cycle, after which the digit-serial accumulators add one
// byte of each 24-bit running sum at a time; no new neighbor is taken until
// the top byte is in. A request that ends the point starts the finishing
// pass: a setup state, the bit-serial squares of the three sums, then the
// root and the divide by the count. A flat neighborhood skips the root and
// the divide. An empty-neighborhood request produces an all-zero result.
// The result channel has its own output register, so the next point's
// neighbors are taken while a result still waits; a finished result that
// finds the register full holds the block until the receiver takes it.
// Reset is synchronous, clears the sums, the count and any pending result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module neighbor_normal_unevenness_top #(
  parameter int MAX_NEIGHBORS = 256
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [nnu_pkg::NORM_W-1:0] in_normal_x,
  input  wire logic signed [nnu_pkg::NORM_W-1:0] in_normal_y,
  input  wire logic signed [nnu_pkg::NORM_W-1:0] in_normal_z,
  input  wire logic                              in_last_neighbor,
  input  wire logic                              in_empty_set,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [nnu_pkg::ACC_W-1:0]       out_sum_x,
  output logic signed [nnu_pkg::ACC_W-1:0]       out_sum_y,
  output logic signed [nnu_pkg::ACC_W-1:0]       out_sum_z,
  output logic [nnu_pkg::UNEV_W-1:0]             out_unevenness
);

  // The count must hold MAX_NEIGHBORS itself.
  localparam int CNT_W    = $clog2(MAX_NEIGHBORS + 1);
  localparam int HALF_W   = (CNT_W > 1) ? (CNT_W - 1) : 1;
  localparam int BND_W    = 2 * HALF_W;
  localparam int SQ_HI_W  = nnu_pkg::SQ_W - nnu_pkg::FLAT_SHIFT;
  localparam int CMP_W    = (BND_W > SQ_HI_W) ? BND_W : SQ_HI_W;

  nnu_pkg::state_t                    state_r, state_nxt;
  logic [CNT_W-1:0]                   count_r, count_nxt;
  logic [nnu_pkg::DIG_CNT_W-1:0]      digit_r, digit_nxt;
  logic                               last_r, last_nxt;
  logic [BND_W-1:0]                   bound_r, bound_nxt;
  logic [nnu_pkg::UNEV_W-1:0]         uneven_r, uneven_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic [nnu_pkg::ACC_W-1:0]          out_sum_x_r, out_sum_x_nxt;
  logic [nnu_pkg::ACC_W-1:0]          out_sum_y_r, out_sum_y_nxt;
  logic [nnu_pkg::ACC_W-1:0]          out_sum_z_r, out_sum_z_nxt;
  logic [nnu_pkg::UNEV_W-1:0]         out_unev_r, out_unev_nxt;

  nnu_pkg::acc_ctl_t                  acc_ctl;
  logic signed [nnu_pkg::ACC_W-1:0]   acc_x, acc_y, acc_z;
  logic                               sq_start, sq_done;
  logic [nnu_pkg::SQ_W-1:0]           sq_sum;
  logic                               sd_start, sd_done;
  logic [nnu_pkg::UNEV_W-1:0]         sd_quot;
  logic                               in_accept;
  logic                               cnt_full;
  logic                               final_digit;
  logic                               flat;
  logic                               out_free;
  logic                               out_load;
  logic [HALF_W-1:0]                  half_cnt;

  assign in_ready    = (state_r == nnu_pkg::ST_IDLE);
  assign in_accept   = in_valid && in_ready;
  assign cnt_full    = (count_r >= CNT_W'(MAX_NEIGHBORS));
  assign final_digit = (digit_r == nnu_pkg::DIG_CNT_W'(nnu_pkg::ACC_DIGITS - 1));
  assign out_free    = !out_valid_r || out_ready;
  assign half_cnt    = HALF_W'(count_r >> 1);

  // The length falls below floor(n/2)*sqrt(2) exactly when the squared raw
  // length, with its low 29 bits dropped, is below floor(n/2) squared.
  assign flat = (CMP_W'(sq_sum[nnu_pkg::SQ_W-1:nnu_pkg::FLAT_SHIFT]) < CMP_W'(bound_r));

  // Per-component digit-serial accumulators.
  nnu_acc u_acc_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (acc_ctl),
    .addend (in_normal_x),
    .acc    (acc_x)
  );

  nnu_acc u_acc_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (acc_ctl),
    .addend (in_normal_y),
    .acc    (acc_y)
  );

  nnu_acc u_acc_z (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (acc_ctl),
    .addend (in_normal_z),
    .acc    (acc_z)
  );

  nnu_sqsum u_sqsum (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (sq_start),
    .val_x  (acc_x),
    .val_y  (acc_y),
    .val_z  (acc_z),
    .sq_sum (sq_sum),
    .done   (sq_done)
  );

  nnu_sqrt_div #(
    .DIV_W (CNT_W)
  ) u_sqrt_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sd_start),
    .sq_sum  (sq_sum),
    .divisor (count_r),
    .quot    (sd_quot),
    .done    (sd_done)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nnu_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (in_empty_set) begin
            state_nxt = nnu_pkg::ST_DONE;
          end else if (!cnt_full) begin
            state_nxt = nnu_pkg::ST_ADD;
          end else if (in_last_neighbor) begin
            // Count is saturated: the normal is dropped but the point ends.
            state_nxt = nnu_pkg::ST_SQ_GO;
          end
        end
      end
      nnu_pkg::ST_ADD: begin
        if (final_digit) begin
          state_nxt = last_r ? nnu_pkg::ST_SQ_GO : nnu_pkg::ST_IDLE;
        end
      end
      nnu_pkg::ST_SQ_GO: begin
        state_nxt = nnu_pkg::ST_SQ;
      end
      nnu_pkg::ST_SQ: begin
        if (sq_done) begin
          state_nxt = flat ? nnu_pkg::ST_DONE : nnu_pkg::ST_ROOT;
        end
      end
      nnu_pkg::ST_ROOT: begin
        if (sd_done) begin
          state_nxt = nnu_pkg::ST_DONE;
        end
      end
      nnu_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = nnu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = nnu_pkg::ST_IDLE;
      end
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    acc_ctl  = '0;
    sq_start = 1'b0;
    sd_start = 1'b0;
    out_load = 1'b0;
    case (state_r)
      nnu_pkg::ST_IDLE: begin
        acc_ctl.clear = in_accept && in_empty_set;
        acc_ctl.load  = in_accept && !in_empty_set && !cnt_full;
      end
      nnu_pkg::ST_ADD: begin
        acc_ctl.step        = 1'b1;
        acc_ctl.final_digit = final_digit;
      end
      nnu_pkg::ST_SQ_GO: begin
        sq_start = 1'b1;
      end
      nnu_pkg::ST_SQ: begin
        sd_start = sq_done && !flat;
      end
      nnu_pkg::ST_ROOT: begin
        sd_start = 1'b0;
      end
      nnu_pkg::ST_DONE: begin
        out_load      = out_free;
        acc_ctl.clear = out_free;
      end
      default: begin
        acc_ctl = '0;
      end
    endcase
  end

  // Datapath registers around the sequencer.
  always_comb begin
    count_nxt  = count_r;
    digit_nxt  = digit_r;
    last_nxt   = last_r;
    bound_nxt  = bound_r;
    uneven_nxt = uneven_r;

    if (in_accept) begin
      last_nxt  = in_last_neighbor;
      digit_nxt = '0;
      if (in_empty_set) begin
        count_nxt  = '0;
        uneven_nxt = '0;
      end else if (!cnt_full) begin
        count_nxt = count_r + 1'b1;
      end
    end

    if (state_r == nnu_pkg::ST_ADD) begin
      digit_nxt = digit_r + 1'b1;
    end

    if (state_r == nnu_pkg::ST_SQ_GO) begin
      bound_nxt = {{HALF_W{1'b0}}, half_cnt} * {{HALF_W{1'b0}}, half_cnt};
    end

    if ((state_r == nnu_pkg::ST_SQ) && sq_done && flat) begin
      uneven_nxt = '0;
    end

    if ((state_r == nnu_pkg::ST_ROOT) && sd_done) begin
      uneven_nxt = sd_quot;
    end

    if (out_load) begin
      count_nxt = '0;
    end
  end

  // Output register: loaded from the sums and the unevenness, held on stall.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_sum_x_nxt = out_sum_x_r;
    out_sum_y_nxt = out_sum_y_r;
    out_sum_z_nxt = out_sum_z_r;
    out_unev_nxt  = out_unev_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_sum_x_nxt = acc_x;
      out_sum_y_nxt = acc_y;
      out_sum_z_nxt = acc_z;
      out_unev_nxt  = uneven_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nnu_pkg::ST_IDLE;
      count_r     <= '0;
      digit_r     <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      digit_r     <= digit_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bound_r     <= bound_nxt;
    uneven_r    <= uneven_nxt;
    out_sum_x_r <= out_sum_x_nxt;
    out_sum_y_r <= out_sum_y_nxt;
    out_sum_z_r <= out_sum_z_nxt;
    out_unev_r  <= out_unev_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_sum_x      = $signed(out_sum_x_r);
  assign out_sum_y      = $signed(out_sum_y_r);
  assign out_sum_z      = $signed(out_sum_z_r);
  assign out_unevenness = out_unev_r;

  // An empty-neighborhood request goes straight to the result stage.
  `ASSERT_NEXT(a_empty_to_done, clk, rst_n, in_accept && in_empty_set, state_r == nnu_pkg::ST_DONE)
  // The squaring unit finishes only while the sequencer waits for it.
  `ASSERT_IMPLY(a_sq_done_in_sq, clk, rst_n, sq_done, state_r == nnu_pkg::ST_SQ)
  // Handing a result over raises out_valid and restarts the count.
  `ASSERT_NEXT(a_done_hands_over, clk, rst_n, (state_r == nnu_pkg::ST_DONE) && out_free, out_valid_r && (count_r == '0))
  // The unevenness never exceeds one.
  `ASSERT_IMPLY(a_unev_bound, clk, rst_n, out_valid, out_unevenness <= nnu_pkg::UNEV_MAX)

endmodule

`default_nettype wire

// ===== rtl/nnu_acc.sv =====
// ----------------------------------------------------------------------------
// nnu_acc
// Digit-serial saturating accumulator for one normal component: one byte of
// the 24-bit sum per cycle, saturation applied on the top byte.
// ----------------------------------------------------------------------------
`default_nettype none

module nnu_acc (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire nnu_pkg::acc_ctl_t                 ctl,
  input  wire logic signed [nnu_pkg::NORM_W-1:0] addend,
  output logic signed [nnu_pkg::ACC_W-1:0]       acc
);

  logic [nnu_pkg::ACC_W-1:0]   acc_r, acc_nxt;
  logic [nnu_pkg::ACC_W-1:0]   add_r, add_nxt;
  logic                        carry_r, carry_nxt;
  logic                        acc_sign_r, acc_sign_nxt;
  logic                        add_sign_r, add_sign_nxt;
  logic [nnu_pkg::DIGIT_W:0]   digit_sum;
  logic                        ovf;

  always_comb begin
    digit_sum = {1'b0, acc_r[nnu_pkg::DIGIT_W-1:0]} + {1'b0, add_r[nnu_pkg::DIGIT_W-1:0]}
              + {{nnu_pkg::DIGIT_W{1'b0}}, carry_r};
    // Overflow only when both operands agree in sign and the result does not.
    ovf = ctl.final_digit && (acc_sign_r == add_sign_r)
          && (digit_sum[nnu_pkg::DIGIT_W-1] != acc_sign_r);
    acc_nxt      = acc_r;
    add_nxt      = add_r;
    carry_nxt    = carry_r;
    acc_sign_nxt = acc_sign_r;
    add_sign_nxt = add_sign_r;
    if (ctl.clear) begin
      acc_nxt = '0;
    end else if (ctl.load) begin
      add_nxt      = {{(nnu_pkg::ACC_W-nnu_pkg::NORM_W){addend[nnu_pkg::NORM_W-1]}}, addend};
      carry_nxt    = 1'b0;
      acc_sign_nxt = acc_r[nnu_pkg::ACC_W-1];
      add_sign_nxt = addend[nnu_pkg::NORM_W-1];
    end else if (ctl.step) begin
      acc_nxt   = {digit_sum[nnu_pkg::DIGIT_W-1:0], acc_r[nnu_pkg::ACC_W-1:nnu_pkg::DIGIT_W]};
      add_nxt   = add_r >> nnu_pkg::DIGIT_W;
      carry_nxt = digit_sum[nnu_pkg::DIGIT_W];
      if (ovf) begin
        acc_nxt = acc_sign_r ? nnu_pkg::ACC_NEG_MIN : nnu_pkg::ACC_POS_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      carry_r <= 1'b0;
    end else begin
      acc_r   <= acc_nxt;
      carry_r <= carry_nxt;
    end
  end

  always_ff @(posedge clk) begin
    add_r      <= add_nxt;
    acc_sign_r <= acc_sign_nxt;
    add_sign_r <= add_sign_nxt;
  end

  assign acc = $signed(acc_r);

endmodule

`default_nettype wire

// ===== rtl/nnu_sqsum.sv =====
// ----------------------------------------------------------------------------
// nnu_sqsum
// Bit-serial squared length: each component magnitude is squared by
// shift-and-add, one multiplier bit per cycle, into one running sum.
// ----------------------------------------------------------------------------
`default_nettype none

module nnu_sqsum (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic signed [nnu_pkg::ACC_W-1:0] val_x,
  input  wire logic signed [nnu_pkg::ACC_W-1:0] val_y,
  input  wire logic signed [nnu_pkg::ACC_W-1:0] val_z,
  output logic [nnu_pkg::SQ_W-1:0]              sq_sum,
  output logic                                  done
);

  localparam logic [1:0] LAST_COMP = 2'd2;

  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [1:0]                      comp_r, comp_nxt;
  logic [nnu_pkg::STEP_CNT_W-1:0]  bit_r, bit_nxt;
  logic [nnu_pkg::SQ_W-1:0]        mcand_r, mcand_nxt;
  logic [nnu_pkg::ACC_W-1:0]       mplier_r, mplier_nxt;
  logic [nnu_pkg::SQ_W-1:0]        sum_r, sum_nxt;
  logic [1:0]                      comp_sel;
  logic [nnu_pkg::ACC_W-1:0]       mag;
  logic                            last_bit;

  function automatic logic [nnu_pkg::ACC_W-1:0] abs_val(input logic [nnu_pkg::ACC_W-1:0] v);
    return v[nnu_pkg::ACC_W-1] ? (~v + 1'b1) : v;
  endfunction

  always_comb begin
    comp_sel = start ? 2'd0 : (comp_r + 2'd1);
    case (comp_sel)
      2'd0:    mag = abs_val(val_x);
      2'd1:    mag = abs_val(val_y);
      default: mag = abs_val(val_z);
    endcase
    last_bit = (bit_r == nnu_pkg::STEP_CNT_W'(nnu_pkg::ACC_W - 1));

    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    comp_nxt   = comp_r;
    bit_nxt    = bit_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    sum_nxt    = sum_r;
    if (start) begin
      busy_nxt   = 1'b1;
      comp_nxt   = 2'd0;
      bit_nxt    = '0;
      mcand_nxt  = {{(nnu_pkg::SQ_W-nnu_pkg::ACC_W){1'b0}}, mag};
      mplier_nxt = mag;
      sum_nxt    = '0;
    end else if (busy_r) begin
      if (mplier_r[0]) begin
        sum_nxt = sum_r + mcand_r;
      end
      mcand_nxt  = mcand_r << 1;
      mplier_nxt = mplier_r >> 1;
      bit_nxt    = bit_r + 1'b1;
      if (last_bit) begin
        if (comp_r == LAST_COMP) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end else begin
          comp_nxt   = comp_r + 2'd1;
          bit_nxt    = '0;
          mcand_nxt  = {{(nnu_pkg::SQ_W-nnu_pkg::ACC_W){1'b0}}, mag};
          mplier_nxt = mag;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      comp_r <= '0;
      bit_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      comp_r <= comp_nxt;
      bit_r  <= bit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    sum_r    <= sum_nxt;
  end

  assign sq_sum = sum_r;
  assign done   = done_r;

endmodule

`default_nettype wire

// ===== rtl/nnu_sqrt_div.sv =====
// ----------------------------------------------------------------------------
// nnu_sqrt_div
// Digit-by-digit integer square root, two radicand bits per cycle, followed
// by a restoring divide, one quotient bit per cycle, in the same register.
// ----------------------------------------------------------------------------
`default_nettype none

module nnu_sqrt_div #(
  parameter int DIV_W = 9
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [nnu_pkg::SQ_W-1:0]    sq_sum,
  input  wire logic [DIV_W-1:0]            divisor,
  output logic [nnu_pkg::UNEV_W-1:0]       quot,
  output logic                             done
);

  logic                            busy_r, busy_nxt;
  logic                            div_phase_r, div_phase_nxt;
  logic                            done_r, done_nxt;
  logic [nnu_pkg::STEP_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [nnu_pkg::RAD_W-1:0]       rad_r, rad_nxt;
  logic [nnu_pkg::REM_W-1:0]       rem_r, rem_nxt;
  logic [nnu_pkg::ROOT_W-1:0]      root_r, root_nxt;
  logic [DIV_W-1:0]                drem_r, drem_nxt;
  logic [nnu_pkg::REM_W+1:0]       rem_sh, trial, rem_diff;
  logic                            root_fit;
  logic [DIV_W:0]                  drem_sh, drem_diff;
  logic                            q_fit;
  logic                            last_step;
  logic                            sat;

  always_comb begin
    rem_sh    = {rem_r, rad_r[nnu_pkg::RAD_W-1 -: 2]};
    trial     = {1'b0, root_r, 2'b01};
    root_fit  = (rem_sh >= trial);
    rem_diff  = rem_sh - trial;
    drem_sh   = {drem_r, root_r[nnu_pkg::ROOT_W-1]};
    q_fit     = (drem_sh >= {1'b0, divisor});
    drem_diff = drem_sh - {1'b0, divisor};
    last_step = (cnt_r == nnu_pkg::STEP_CNT_W'(nnu_pkg::ROOT_W - 1));

    busy_nxt      = busy_r;
    div_phase_nxt = div_phase_r;
    done_nxt      = 1'b0;
    cnt_nxt       = cnt_r;
    rad_nxt       = rad_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    drem_nxt      = drem_r;
    if (start) begin
      busy_nxt      = 1'b1;
      div_phase_nxt = 1'b0;
      cnt_nxt       = '0;
      rad_nxt       = {sq_sum, {nnu_pkg::RAD_SHIFT{1'b0}}};
      rem_nxt       = '0;
      root_nxt      = '0;
    end else if (busy_r && !div_phase_r) begin
      rad_nxt  = rad_r << 2;
      rem_nxt  = root_fit ? rem_diff[nnu_pkg::REM_W-1:0] : rem_sh[nnu_pkg::REM_W-1:0];
      root_nxt = {root_r[nnu_pkg::ROOT_W-2:0], root_fit};
      cnt_nxt  = cnt_r + 1'b1;
      if (last_step) begin
        div_phase_nxt = 1'b1;
        cnt_nxt       = '0;
        drem_nxt      = '0;
      end
    end else if (busy_r) begin
      // The root shifts out from the top while quotient bits enter below.
      drem_nxt = q_fit ? drem_diff[DIV_W-1:0] : drem_sh[DIV_W-1:0];
      root_nxt = {root_r[nnu_pkg::ROOT_W-2:0], q_fit};
      cnt_nxt  = cnt_r + 1'b1;
      if (last_step) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      div_phase_r <= 1'b0;
      done_r      <= 1'b0;
      cnt_r       <= '0;
    end else begin
      busy_r      <= busy_nxt;
      div_phase_r <= div_phase_nxt;
      done_r      <= done_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    drem_r <= drem_nxt;
  end

  always_comb begin
    sat = (|root_r[nnu_pkg::ROOT_W-1:nnu_pkg::UNEV_W])
          || (root_r[nnu_pkg::UNEV_W-1] && (|root_r[nnu_pkg::UNEV_W-2:0]));
    quot = sat ? nnu_pkg::UNEV_MAX : root_r[nnu_pkg::UNEV_W-1:0];
  end

  assign done = done_r;

endmodule

`default_nettype wire

// ===== sim/neighbor_normal_unevenness_top_tb.sv =====
// ----------------------------------------------------------------------------
// neighbor_normal_unevenness_top_tb
// Self-checking bench for the neighbor normal unevenness block. Neighbor
// normals are sent as points of varying size with random idling on both
// channels. A scoreboard keeps its own running sums and count, predicts each
// point's descriptor and compares it, field by field, with what the block
// returns.
// ----------------------------------------------------------------------------
module neighbor_normal_unevenness_top_tb;
  import nnu_pkg::*;

  localparam int NEIGHBOR_CAP = 256;
  localparam int SUM_HI = 2 ** (ACC_W - 1) - 1;
  localparam int SUM_LO = -(2 ** (ACC_W - 1));
  localparam int TARGET_NEIGHBORS = 1800;

  // One descriptor as the result channel carries it.
  typedef struct packed {
    logic signed [ACC_W-1:0] sum_x;
    logic signed [ACC_W-1:0] sum_y;
    logic signed [ACC_W-1:0] sum_z;
    logic [UNEV_W-1:0]       unevenness;
  } descriptor_t;

  // How the normals of a random point are chosen.
  typedef enum {
    PT_SCATTER,  // independent in-range normals, usually a flat result
    PT_ALIGNED,  // one direction plus small noise, usually a nonzero result
    PT_WILD,     // any 16-bit pattern, out of range included
    PT_FLOOR     // every component at the most negative code
  } point_kind_t;

  // Scoreboard: it mirrors the block's sums and count, and keeps the
  // descriptors that accepted requests still owe in arrival order.
  class descriptor_scoreboard;
    descriptor_t             expected_descriptors[$];
    logic signed [ACC_W-1:0] run_x, run_y, run_z;
    int unsigned             run_count;
    int unsigned             cap;
    int unsigned             error_count;

    function new(int unsigned neighbor_cap);
      cap = neighbor_cap;
      error_count = 0;
      clear_point();
    endfunction

    function void clear_point();
      run_x = '0;
      run_y = '0;
      run_z = '0;
      run_count = 0;
    endfunction

    function logic signed [ACC_W-1:0] clamp_add(logic signed [ACC_W-1:0] a,
                                                logic signed [NORM_W-1:0] b);
      int s;
      s = int'(a) + int'(b);
      if (s > SUM_HI) s = SUM_HI;
      if (s < SUM_LO) s = SUM_LO;
      return s[ACC_W-1:0];
    endfunction

    // Floor of the square root, one result bit at a time from the top.
    function longint unsigned root_floor(longint unsigned v);
      longint unsigned r, c;
      r = 0;
      for (int b = 26; b >= 0; b--) begin
        c = r | (64'd1 << b);
        if (c * c <= v) r = c;
      end
      return r;
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $time, what);
      error_count++;
    endtask

    // Folds one accepted request into the running point and queues the
    // descriptor it causes, if any.
    function void note_neighbor(logic [NORM_W-1:0] nx, logic [NORM_W-1:0] ny,
                                logic [NORM_W-1:0] nz, logic last, logic empty);
      descriptor_t     d;
      longint          sx, sy, sz;
      longint unsigned sq, floor_sq, quo;
      int unsigned     half;
      if (empty) begin
        clear_point();
        expected_descriptors.push_back('0);
        return;
      end
      if (run_count < cap) begin
        run_x = clamp_add(run_x, nx);
        run_y = clamp_add(run_y, ny);
        run_z = clamp_add(run_z, nz);
        run_count++;
      end
      if (!last) return;
      sx = longint'(run_x);
      sy = longint'(run_y);
      sz = longint'(run_z);
      sq = sx * sx + sy * sy + sz * sz;
      half = run_count / 2;
      floor_sq = (longint'(half) * half) << FLAT_SHIFT;
      if (run_count == 0 || sq < floor_sq) begin
        quo = 0;
      end else begin
        quo = root_floor(sq << RAD_SHIFT) / run_count;
        if (quo > 64'(UNEV_MAX)) quo = 64'(UNEV_MAX);
      end
      d.sum_x = run_x;
      d.sum_y = run_y;
      d.sum_z = run_z;
      d.unevenness = quo[UNEV_W-1:0];
      expected_descriptors.push_back(d);
      clear_point();
    endfunction

    task check_descriptor(descriptor_t got);
      descriptor_t want;
      if (expected_descriptors.size() == 0) begin
        report_mismatch($sformatf("descriptor with none expected, sum %0d %0d %0d",
                                  got.sum_x, got.sum_y, got.sum_z));
        return;
      end
      want = expected_descriptors.pop_front();
      if (got.sum_x !== want.sum_x)
        report_mismatch($sformatf("sum_x got %0d expected %0d", got.sum_x, want.sum_x));
      if (got.sum_y !== want.sum_y)
        report_mismatch($sformatf("sum_y got %0d expected %0d", got.sum_y, want.sum_y));
      if (got.sum_z !== want.sum_z)
        report_mismatch($sformatf("sum_z got %0d expected %0d", got.sum_z, want.sum_z));
      if (got.unevenness !== want.unevenness)
        report_mismatch($sformatf("unevenness got %0d expected %0d",
                                  got.unevenness, want.unevenness));
    endtask

    function int unsigned outstanding();
      return expected_descriptors.size();
    endfunction
  endclass

  // Every input of the block starts at a known value.
  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [NORM_W-1:0]  in_normal_x = '0;
  logic signed [NORM_W-1:0]  in_normal_y = '0;
  logic signed [NORM_W-1:0]  in_normal_z = '0;
  logic                      in_last_neighbor = 1'b0;
  logic                      in_empty_set = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [ACC_W-1:0]   out_sum_x;
  logic signed [ACC_W-1:0]   out_sum_y;
  logic signed [ACC_W-1:0]   out_sum_z;
  logic [UNEV_W-1:0]         out_unevenness;

  descriptor_scoreboard board;
  descriptor_t          seen_descriptor;
  bit                   no_idle = 1'b0;
  int unsigned          neighbors_sent = 0;

  neighbor_normal_unevenness_top #(
    .MAX_NEIGHBORS(NEIGHBOR_CAP)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_normal_x     (in_normal_x),
    .in_normal_y     (in_normal_y),
    .in_normal_z     (in_normal_z),
    .in_last_neighbor(in_last_neighbor),
    .in_empty_set    (in_empty_set),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sum_x       (out_sum_x),
    .out_sum_y       (out_sum_y),
    .out_sum_z       (out_sum_z),
    .out_unevenness  (out_unevenness)
  );

  always #1 clk = ~clk;

  // The receiver drops ready in about one cycle of ten, except during the
  // quiet stretch. Ready changes only at the falling edge.
  always @(negedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= 10);
  end

  // Results are taken at the rising edge, where the outputs still hold the
  // values of the cycle that ends there.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen_descriptor.sum_x = out_sum_x;
      seen_descriptor.sum_y = out_sum_y;
      seen_descriptor.sum_z = out_sum_z;
      seen_descriptor.unevenness = out_unevenness;
      board.check_descriptor(seen_descriptor);
    end
  end

  // Sends one request. It is entered at a falling edge and returns at the
  // falling edge after the request was taken. Valid stays high between
  // back-to-back requests; it drops only for an idle gap or a phase change.
  task automatic send_neighbor(logic [NORM_W-1:0] nx, logic [NORM_W-1:0] ny,
                               logic [NORM_W-1:0] nz, logic last, logic empty);
    int gap;
    gap = 0;
    if (!no_idle) begin
      while ($urandom_range(99) < 10) gap++;
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_normal_x <= nx;
    in_normal_y <= ny;
    in_normal_z <= nz;
    in_last_neighbor <= last;
    in_empty_set <= empty;
    do @(posedge clk); while (!in_ready);
    board.note_neighbor(nx, ny, nz, last, empty);
    neighbors_sent++;
    @(negedge clk);
  endtask

  // Sends an empty-neighborhood request with a random payload and last flag.
  task automatic send_empty();
    send_neighbor(NORM_W'($urandom()), NORM_W'($urandom()), NORM_W'($urandom()),
                  1'($urandom_range(1)), 1'b1);
  endtask

  // Holds the sender back until every owed descriptor has arrived.
  task automatic drain_descriptors();
    in_valid <= 1'b0;
    do @(negedge clk); while (board.outstanding() != 0);
  endtask

  // Sends one point of n neighbors. A broken point has an empty-neighborhood
  // request dropped in at a random place, which ends it early; the rest of
  // its neighbors then form a point of their own.
  task automatic send_point(int unsigned n, point_kind_t kind, bit broken);
    int               bx, by, bz;
    int unsigned      cut;
    logic [NORM_W-1:0] c[3];
    bx = int'($urandom_range(32768)) - 16384;
    by = int'($urandom_range(32768)) - 16384;
    bz = int'($urandom_range(32768)) - 16384;
    cut = broken ? $urandom_range(n - 1) : n;
    for (int unsigned i = 0; i < n; i++) begin
      if (i == cut) begin
        send_empty();
      end
      case (kind)
        PT_SCATTER: begin
          for (int k = 0; k < 3; k++) c[k] = NORM_W'(int'($urandom_range(32768)) - 16384);
        end
        PT_ALIGNED: begin
          c[0] = NORM_W'(bx + int'($urandom_range(1024)) - 512);
          c[1] = NORM_W'(by + int'($urandom_range(1024)) - 512);
          c[2] = NORM_W'(bz + int'($urandom_range(1024)) - 512);
        end
        PT_WILD: begin
          for (int k = 0; k < 3; k++) c[k] = NORM_W'($urandom());
        end
        default: begin
          for (int k = 0; k < 3; k++) c[k] = 16'h8000;
        end
      endcase
      send_neighbor(c[0], c[1], c[2], i == n - 1, 1'b0);
    end
  endtask

  // Ends a hung run.
  initial begin
    #5000000;
    $display("neighbor_normal_unevenness_top_tb: done, errors");
    $finish;
  end

  initial begin
    int unsigned  size, pick;
    point_kind_t  kind;
    bit           big_floor_done, big_aligned_done, mid_drain_done;
    board = new(NEIGHBOR_CAP);
    big_floor_done = 1'b0;
    big_aligned_done = 1'b0;
    mid_drain_done = 1'b0;

    // Synchronous reset, released at a falling edge.
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. A single unit normal gives exactly 1.0.
    send_neighbor(16'sd16384, 16'sd0, 16'sd0, 1'b1, 1'b0);
    // Longer than unit normals drive the value into saturation.
    send_neighbor(-16'sd16384, -16'sd16384, -16'sd16384, 1'b1, 1'b0);
    send_neighbor(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 1'b0);
    send_neighbor(16'h8000, 16'h8000, 16'h8000, 1'b1, 1'b0);
    // Empty neighborhood: the payload is ignored, with and without last.
    send_neighbor(16'h7FFF, 16'h8000, 16'h1234, 1'b1, 1'b1);
    send_neighbor(16'h0000, 16'hFFFF, 16'h5555, 1'b0, 1'b1);
    // Opposite normals cancel, so the point counts as flat.
    send_neighbor(16'sd16384, 16'sd0, 16'sd0, 1'b0, 1'b0);
    send_neighbor(-16'sd16384, 16'sd0, 16'sd0, 1'b1, 1'b0);
    // A partial point is thrown away by an empty-neighborhood request.
    send_neighbor(16'sd1000, 16'sd2000, 16'sd3000, 1'b0, 1'b0);
    send_neighbor(16'sd4000, 16'sd5000, 16'sd6000, 1'b0, 1'b0);
    send_neighbor(16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1);
    // A lone zero normal: one neighbor is never forced flat, the value is 0.
    send_neighbor(16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0);
    // Three equal normals, right at the 1.0 cap.
    repeat (2) send_neighbor(16'sd0, 16'sd16384, 16'sd0, 1'b0, 1'b0);
    send_neighbor(16'sd0, 16'sd16384, 16'sd0, 1'b1, 1'b0);
    // Four normals whose sum stays below the flatness bound.
    send_neighbor(16'sd0, 16'sd0, 16'sd16384, 1'b0, 1'b0);
    send_neighbor(16'sd0, 16'sd0, -16'sd16384, 1'b0, 1'b0);
    send_neighbor(16'sd0, 16'sd0, 16'sd16384, 1'b0, 1'b0);
    send_neighbor(16'sd0, 16'sd0, 16'sd16384, 1'b1, 1'b0);
    // Three normals above the bound give a fractional value.
    send_neighbor(16'sd0, 16'sd0, 16'sd16384, 1'b0, 1'b0);
    send_neighbor(16'sd0, 16'sd0, 16'sd16384, 1'b0, 1'b0);
    send_neighbor(16'sd16384, 16'sd0, 16'sd0, 1'b1, 1'b0);

    // Let the directed descriptors come back before the random traffic.
    drain_descriptors();

    // Random part: mostly well-formed points, a few broken ones and lone
    // empty requests. Two points run past the neighbor cap.
    while (neighbors_sent < TARGET_NEIGHBORS) begin
      no_idle = (neighbors_sent >= 900 && neighbors_sent < 1150);
      if (!mid_drain_done && neighbors_sent >= 1300) begin
        drain_descriptors();
        mid_drain_done = 1'b1;
      end
      if (!big_floor_done && neighbors_sent >= 500) begin
        send_point(NEIGHBOR_CAP + $urandom_range(1, 6), PT_FLOOR, 1'b0);
        big_floor_done = 1'b1;
      end else if (!big_aligned_done && neighbors_sent >= 1500) begin
        send_point(NEIGHBOR_CAP + $urandom_range(1, 6), PT_ALIGNED, 1'b0);
        big_aligned_done = 1'b1;
      end else begin
        pick = $urandom_range(99);
        if (pick < 80) size = $urandom_range(1, 8);
        else if (pick < 95) size = $urandom_range(9, 40);
        else size = $urandom_range(41, 120);
        pick = $urandom_range(99);
        if (pick < 45) kind = PT_ALIGNED;
        else if (pick < 80) kind = PT_SCATTER;
        else kind = PT_WILD;
        pick = $urandom_range(99);
        if (pick < 5) begin
          send_empty();
        end else begin
          send_point(size, kind, pick < 12 && size > 1);
        end
      end
    end
    no_idle = 1'b0;

    // Wait for the last descriptors, then give the block time to show any
    // stray output before the verdict.
    drain_descriptors();
    repeat (300) @(negedge clk);
    if (board.error_count == 0 && board.outstanding() == 0) begin
      $display("neighbor_normal_unevenness_top_tb: done, clean");
    end else begin
      $display("neighbor_normal_unevenness_top_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/nnu_pkg.sv
rtl/nnu_acc.sv
rtl/nnu_sqsum.sv
rtl/nnu_sqrt_div.sv
rtl/neighbor_normal_unevenness_top.sv
sim/neighbor_normal_unevenness_top_tb.sv
